### rtl/core/mrss_pkg.sv
// Package for the Morton range split search block.
// Holds table sizes, transfer structs and the controller/datapath command codes.
// Used by mrss_ctrl, mrss_dp and morton_range_split_search.
package mrss_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CODE_W      = 32;

  // Table depth as an index-plus-one-bit value for range checks
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(TABLE_DEPTH);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Read address select
  localparam logic [1:0] RD_LO    = 2'd0;
  localparam logic [1:0] RD_HI    = 2'd1;
  localparam logic [1:0] RD_PROBE = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  load_index;
    logic [CODE_W-1:0] load_code;
    logic [IDX_W-1:0]  range_start;
    logic [IDX_W-1:0]  range_end;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] split_index;
    logic             bad_range;
  } res_t;

  typedef struct packed {
    logic       capture;
    logic       load_wr;
    logic [1:0] rd_sel;
    logic       cap_first;
    logic       setup;
    logic       step;
    logic       check;
    logic       res_bad;
    logic       res_mid;
    logic       res_pos;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic bad;
    logic ends_equal;
    logic more_steps;
  } stat_t;

endpackage

### rtl/core/mrss_dp.sv
// Datapath of the Morton range split search: code table memory, search registers
// and result register. Driven by mrss_ctrl; depends on mrss_pkg.
module mrss_dp (
  input  logic          clk,
  input  mrss_pkg::req_t  req,
  input  mrss_pkg::cmd_t  cmd,
  output mrss_pkg::stat_t stat,
  output mrss_pkg::res_t  res
);
  import mrss_pkg::*;

  logic [CODE_W-1:0] mem [TABLE_DEPTH];
  logic [CODE_W-1:0] rdata;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  pos;
  logic [IDX_W-1:0]  stride;
  logic [IDX_W:0]    probe;
  logic [CODE_W-1:0] first;
  logic [CODE_W-1:0] keep;

  logic [IDX_W-1:0]  stride_next;
  logic [IDX_W:0]    probe_next;
  logic [IDX_W:0]    stride_inc;
  logic [IDX_W:0]    mid_sum;
  logic [CODE_W-1:0] diff;
  logic [CODE_W-1:0] smear;
  logic              hit;
  logic [IDX_W-1:0]  pos_upd;

  // Table write on load transfer, registered read
  always_ff @(posedge clk) begin
    if (cmd.load_wr && ({1'b0, req.load_index} < DEPTH_LIM)) begin
      mem[req.load_index] <= req.load_code;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_LO:    rd_addr = lo;
      RD_HI:    rd_addr = hi;
      RD_PROBE: rd_addr = probe_next[IDX_W-1:0];
      default:  rd_addr = lo;
    endcase
  end

  assign stride_inc  = {1'b0, stride} + (IDX_W + 1)'(1);
  assign stride_next = stride_inc[IDX_W:1];
  assign probe_next  = {1'b0, pos} + {1'b0, stride_next};
  assign mid_sum     = {1'b0, lo} + {1'b0, hi};

  // Bits at and below the top set bit of first ^ last
  assign diff = first ^ rdata;
  always_comb begin
    smear = diff;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
  end

  // Probe shares a longer prefix when no bit at or above the split bit differs
  assign hit     = (probe < {1'b0, hi}) && ((diff & ~keep) == '0);
  assign pos_upd = hit ? probe[IDX_W-1:0] : pos;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lo <= req.range_start;
      hi <= req.range_end;
    end
    if (cmd.cap_first) begin
      first <= rdata;
    end
    if (cmd.setup) begin
      keep   <= smear >> 1;
      stride <= hi - lo;
      pos    <= lo;
    end
    if (cmd.step) begin
      stride <= stride_next;
      probe  <= probe_next;
    end
    if (cmd.check) begin
      pos <= pos_upd;
    end
    if (cmd.res_bad) begin
      res.split_index <= '0;
      res.bad_range   <= 1'b1;
    end else if (cmd.res_mid) begin
      res.split_index <= mid_sum[IDX_W:1];
      res.bad_range   <= 1'b0;
    end else if (cmd.res_pos) begin
      res.split_index <= pos_upd;
      res.bad_range   <= 1'b0;
    end
  end

  assign stat.is_query   = (req.req_type == REQ_QUERY);
  assign stat.bad        = (req.range_start > req.range_end) ||
                           ({1'b0, req.range_end} >= DEPTH_LIM);
  assign stat.ends_equal = (first == rdata);
  assign stat.more_steps = (stride > (IDX_W)'(1));

endmodule

### rtl/core/mrss_ctrl.sv
// Controller of the Morton range split search: sequences table reads and
// halving steps, and raises the result strobe. Depends on mrss_pkg.
module mrss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mrss_pkg::stat_t stat,
  output mrss_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);
  import mrss_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_FIRST = 3'd1;
  localparam logic [2:0] S_RD_LAST  = 3'd2;
  localparam logic [2:0] S_COMPARE  = 3'd3;
  localparam logic [2:0] S_STEP     = 3'd4;
  localparam logic [2:0] S_CHECK    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_LO;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (!stat.is_query) begin
            cmd.load_wr = 1'b1;
          end else if (stat.bad) begin
            cmd.res_bad = 1'b1;
            done_next   = 1'b1;
          end else begin
            state_next = S_RD_FIRST;
          end
        end
      end
      S_RD_FIRST: begin
        cmd.rd_sel = RD_LO;
        state_next = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd.rd_sel    = RD_HI;
        cmd.cap_first = 1'b1;
        state_next    = S_COMPARE;
      end
      S_COMPARE: begin
        if (stat.ends_equal) begin
          cmd.res_mid = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.setup  = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.rd_sel = RD_PROBE;
        cmd.step   = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (stat.more_steps) begin
          state_next = S_STEP;
        end else begin
          cmd.res_pos = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

### rtl/core/morton_range_split_search.sv
// Top level of the Morton range split search block.
// Instantiates mrss_ctrl and mrss_dp; depends on mrss_pkg.
//
// Usage:
//   Input channel: drive req and raise start; the transfer happens at the rising
//   edge where start is high and busy is low. req_type selects a load (write
//   load_code at load_index of the code table) or a split query over the
//   inclusive range [range_start, range_end]. The table must hold sorted codes
//   and every entry a query touches must have been loaded since reset.
//   Result channel: done pulses for one cycle with res valid; the receiver
//   cannot stall it, so take the transfer in that cycle.
//   Sequence: a load finishes at its transfer edge and gives no result. A bad
//   range reports in the cycle after transfer. A query reads the start and end
//   codes; if they are equal it reports the midpoint, otherwise it runs S
//   halving steps, where S = ceil(log2(end - start)), at least 1 and at most 10.
//   Each step is one registered read of the single table port and one compare
//   of the probe code against the start code. The next item may be offered in
//   the cycle the result strobe is up.
//   Reset: clears the controller and the strobe; the table content stays
//   undefined until written.
module morton_range_split_search (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mrss_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output mrss_pkg::res_t res
);
  import mrss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence reads and halving steps
  mrss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold the table, the search registers and the result register
  mrss_dp u_dp (
    .clk  (clk),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .res  (res)
  );

endmodule

### bench/morton_split_checker.sv
`timescale 1ns / 1ps
// Result checker for morton_range_split_search: mirrors the code table from load
// transfers, predicts the split of each query and compares every result strobe.
// Depends on mrss_pkg for the request and result structs and the table sizes.
module morton_split_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  mrss_pkg::req_t req,
  input  logic           done,
  input  mrss_pkg::res_t res,
  output int             errors,
  output int             pending
);
  import mrss_pkg::*;

  logic [CODE_W-1:0] code_copy [TABLE_DEPTH];
  res_t              expected_splits [$];
  int                fail_count = 0;
  int                waiting = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  function automatic int lead_zero_count(logic [CODE_W-1:0] word);
    int n;
    n = 0;
    for (int b = CODE_W - 1; b >= 0; b--) begin
      if (word[b]) return n;
      n++;
    end
    return n;
  endfunction

  function automatic res_t predict_split(logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
    res_t              r;
    logic [CODE_W-1:0] first, last;
    int unsigned       lo_i, hi_i, pos, stride, probe;
    int                prefix;
    r = '0;
    lo_i = lo;
    hi_i = hi;
    if (lo_i > hi_i || {1'b0, hi} >= DEPTH_LIM) begin
      r.bad_range = 1'b1;
      return r;
    end
    first = code_copy[lo_i];
    last  = code_copy[hi_i];
    if (first == last) begin
      pos = (lo_i + hi_i) >> 1;
      r.split_index = pos[IDX_W-1:0];
      return r;
    end
    // Halving search: keep the furthest probe below the end that shares
    // a longer prefix with the start code than the end code does.
    prefix = lead_zero_count(first ^ last);
    pos    = lo_i;
    stride = hi_i - lo_i;
    do begin
      stride = (stride + 1) >> 1;
      probe  = pos + stride;
      if (probe < hi_i && lead_zero_count(first ^ code_copy[probe]) > prefix) pos = probe;
    end while (stride > 1);
    r.split_index = pos[IDX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_splits.size() == 0) begin
          $display("%0t: unexpected result: split %0d bad_range %0b",
                   $time, res.split_index, res.bad_range);
          fail_count++;
        end else begin
          res_t want;
          want = expected_splits.pop_front();
          if (res.split_index !== want.split_index) begin
            $display("%0t: split_index expected %0d actual %0d",
                     $time, want.split_index, res.split_index);
            fail_count++;
          end
          if (res.bad_range !== want.bad_range) begin
            $display("%0t: bad_range expected %0b actual %0b",
                     $time, want.bad_range, res.bad_range);
            fail_count++;
          end
        end
      end
      // Predict at the transfer edge; no load can slip in while a query runs.
      if (start && !busy) begin
        if (req.req_type == REQ_LOAD) begin
          if ({1'b0, req.load_index} < DEPTH_LIM) code_copy[req.load_index] = req.load_code;
        end else begin
          expected_splits = {expected_splits, predict_split(req.range_start, req.range_end)};
        end
      end
      waiting = expected_splits.size();
    end
  end

endmodule

### bench/tb_morton_range_split_search.sv
`timescale 1ns / 1ps
// Testbench top for morton_range_split_search: drives load and split query
// transfers with random gaps and gives the verdict from morton_split_checker.
// Depends on mrss_pkg, the block and bench/morton_split_checker.sv.
module tb_morton_range_split_search;
  import mrss_pkg::*;

  localparam int ITEM_TARGET    = 750;
  // Slowest transfer-free stretch: the longest random gap or the longest search.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  res_t res;
  int   errors;
  int   pending;

  int   sent = 0;
  int   idle_cycles = 0;
  bit   steady = 1'b0;         // set for episodes sent back to back
  bit   loaded [TABLE_DEPTH];  // entries written since reset; valid-range queries stay inside these

  always #4 clk = ~clk;

  morton_range_split_search i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .res   (res)
  );

  morton_split_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .res     (res),
    .errors  (errors),
    .pending (pending)
  );

  // Watchdog: abort when neither a transfer nor a result shows up for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_morton_range_split_search failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all in a steady episode.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item and hold it until the transfer edge. Called at a rising
  // edge; start only gets one assignment per step, so back-to-back items
  // keep start high without a glitch.
  task automatic send_item(req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    sent++;
    if (item.req_type == REQ_LOAD) loaded[item.load_index] = 1'b1;
  endtask

  // Query fields ride along with random junk; the block must ignore them.
  function automatic req_t make_load(int unsigned idx, logic [CODE_W-1:0] code);
    req_t item;
    item.req_type    = REQ_LOAD;
    item.load_index  = IDX_W'(idx);
    item.load_code   = code;
    item.range_start = IDX_W'($urandom);
    item.range_end   = IDX_W'($urandom);
    return item;
  endfunction

  function automatic req_t make_query(int unsigned lo, int unsigned hi);
    req_t item;
    item.req_type    = REQ_QUERY;
    item.load_index  = IDX_W'($urandom);
    item.load_code   = $urandom;
    item.range_start = IDX_W'(lo);
    item.range_end   = IDX_W'(hi);
    return item;
  endfunction

  // Last index of the written run that begins at lo.
  function automatic int unsigned run_end(int unsigned lo);
    int unsigned hi;
    hi = lo;
    while (hi + 1 < TABLE_DEPTH && loaded[hi + 1]) hi++;
    return hi;
  endfunction

  // Fill [base, base+len) with codes. Most windows are sorted with a random
  // step size (tiny steps give long shared prefixes, huge ones saturate at
  // all ones); some hold one repeated code, some are plain unsorted noise.
  task automatic load_window(int unsigned base, int unsigned len);
    logic [CODE_W:0]   acc;
    logic [CODE_W-1:0] mask;
    int                shape;
    shape = $urandom_range(0, 9);
    acc   = {1'b0, $urandom >> $urandom_range(0, 31)};
    mask  = (32'h1 << $urandom_range(0, 31)) - 32'h1;
    for (int unsigned i = 0; i < len; i++) begin
      if (shape == 1) begin
        acc = {1'b0, $urandom};
      end else if (shape != 0 && $urandom_range(0, 6) != 0) begin
        acc = acc + {1'b0, mask & $urandom};
        if (acc[CODE_W]) acc = {1'b0, {CODE_W{1'b1}}};
      end
      send_item(make_load(base + i, acc[CODE_W-1:0]));
    end
  endtask

  // One query: a bad range, the whole window, a piece of it, or any written run.
  task automatic random_query(int unsigned base, int unsigned last);
    int unsigned lo, hi;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      lo = $urandom_range(1, TABLE_DEPTH - 1);
      hi = $urandom_range(0, lo - 1);
    end else if (r < 35) begin
      lo = base;
      hi = last;
    end else if (r < 80) begin
      lo = $urandom_range(base, last);
      hi = $urandom_range(lo, last);
    end else begin
      do lo = $urandom_range(0, TABLE_DEPTH - 1); while (!loaded[lo]);
      hi = $urandom_range(lo, run_end(lo));
    end
    send_item(make_query(lo, hi));
  endtask

  initial begin
    int unsigned base, len, spot;
    int          r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme codes at both ends of the table, then queries over them.
    send_item(make_load(0, 32'h0000_0000));
    send_item(make_load(1, 32'h0000_0001));
    send_item(make_load(2, 32'h7FFF_FFFF));
    send_item(make_load(3, 32'h8000_0000));
    send_item(make_load(4, 32'hFFFF_FFFF));
    send_item(make_load(5, 32'h4000_0000));  // breaks the sort order on purpose
    send_item(make_load(1021, 32'h1234_5678));
    send_item(make_load(1022, 32'hFFFF_FFFF));
    send_item(make_load(1023, 32'hFFFF_FFFF));
    send_item(make_query(0, 0));         // single element
    send_item(make_query(1023, 1023));   // single element at the top index
    send_item(make_query(0, 4));         // codes differ in the top bit
    send_item(make_query(0, 1));         // codes differ in the bottom bit only
    send_item(make_query(2, 3));
    send_item(make_query(3, 4));
    send_item(make_query(0, 2));
    send_item(make_query(0, 5));         // unsorted run
    send_item(make_query(3, 5));
    send_item(make_query(1022, 1023));   // equal end codes: midpoint
    send_item(make_query(1021, 1023));
    send_item(make_query(5, 4));         // start past end
    send_item(make_query(1023, 0));
    send_item(make_query(1, 0));

    // Random: mostly a freshly loaded window followed by queries inside it,
    // with some stray loads and loose queries mixed in.
    while (sent < ITEM_TARGET) begin
      steady = ($urandom_range(0, 99) < 30);
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(2, 16);
        else if (r < 93) len = $urandom_range(17, 64);
        else len = $urandom_range(65, 200);
        base = $urandom_range(0, TABLE_DEPTH - len);
        load_window(base, len);
        repeat ($urandom_range(2, 8)) random_query(base, base + len - 1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_item(make_load($urandom_range(0, TABLE_DEPTH - 1), $urandom));
          end else begin
            do spot = $urandom_range(0, TABLE_DEPTH - 1); while (!loaded[spot]);
            random_query(spot, spot);
          end
        end
      end
    end
    start <= 1'b0;

    // Drain: wait out the last search, then give the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_morton_range_split_search passed");
    end else begin
      $display("tb_morton_range_split_search failed");
    end
    $finish;
  end

endmodule
